// File: hdl/diagnostic_event_status_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the diagnostic event status table
// Same-cycle and next-cycle implication checks with asynchronous reset gating.
// ----------------------------------------------------------------------------
`ifndef DIAGNOSTIC_EVENT_STATUS_TABLE_ASSERT_SVH
`define DIAGNOSTIC_EVENT_STATUS_TABLE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DEST_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dest: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define DEST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dest: next-cycle check failed");

`endif

// File: hdl/dest_pkg.sv
// ----------------------------------------------------------------------------
// Diagnostic event status table package
// Sizes, operation and outcome codes, and shared types.
// ----------------------------------------------------------------------------
package dest_pkg;

    localparam int ENTRIES   = 16;
    localparam int ID_BITS   = 16;
    localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS  = $clog2(ENTRIES + 1);
    localparam int MODE_BITS = 2;
    localparam int EVID_BITS = 16;

    localparam logic [MODE_BITS-1:0] MODE_REPORT = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_CHECK  = 2'd2;

    typedef enum logic [1:0] {
        OUT_NEW     = 2'd0,
        OUT_FOUND   = 2'd1,
        OUT_FULL    = 2'd2,
        OUT_MISSING = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic                we;
        logic [IDX_BITS-1:0] waddr;
        logic [ID_BITS-1:0]  wdata;
        logic [IDX_BITS-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        outcome_t outcome;
        logic     active;
    } res_t;

endpackage

// File: hdl/dest_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying the operation and the event id.
// ----------------------------------------------------------------------------
interface dest_req_if;
    logic                           valid;
    logic                           ready;
    logic [dest_pkg::MODE_BITS-1:0] mode;
    logic [dest_pkg::EVID_BITS-1:0] evt_id;

    modport source (output valid, output mode, output evt_id, input ready);
    modport sink (input valid, input mode, input evt_id, output ready);
endinterface

// File: hdl/dest_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the outcome code and the active flag.
// ----------------------------------------------------------------------------
interface dest_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         outcome;
    logic               active;

    modport source (output valid, output outcome, output active, input ready);
    modport sink (input valid, input outcome, input active, output ready);
endinterface

// File: hdl/dest_id_mem.sv
// ----------------------------------------------------------------------------
// Event id store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dest_id_mem (
    input  logic                         clk,
    input  dest_pkg::mem_req_t           req,
    output logic [dest_pkg::ID_BITS-1:0] rd_data
);

    logic [dest_pkg::ID_BITS-1:0] mem [dest_pkg::ENTRIES];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data <= mem[req.raddr];
    end

endmodule

// File: hdl/dest_ctrl.sv
// ----------------------------------------------------------------------------
// Table sequencer
// Scans the stored ids one a cycle through a single comparator, then
// updates the flags, appends new ids and forms the outcome.
// ----------------------------------------------------------------------------
module dest_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [dest_pkg::MODE_BITS-1:0] in_mode,
    input  logic [dest_pkg::EVID_BITS-1:0] in_evt_id,
    output logic                           in_ready,
    output dest_pkg::mem_req_t             mem,
    input  logic [dest_pkg::ID_BITS-1:0]   rd_data,
    output logic                           res_valid,
    output dest_pkg::res_t                 res,
    input  logic                           res_take
);

    dest_pkg::state_t                 state_reg, state_next;
    logic [dest_pkg::MODE_BITS-1:0]   mode_reg, mode_next;
    logic [dest_pkg::ID_BITS-1:0]     id_reg, id_next;
    logic [dest_pkg::CNT_BITS-1:0]    scan_reg, scan_next;
    logic                             pend_reg, pend_next;
    logic [dest_pkg::IDX_BITS-1:0]    pend_idx_reg, pend_idx_next;
    logic                             hit_reg, hit_next;
    logic [dest_pkg::IDX_BITS-1:0]    hit_idx_reg, hit_idx_next;
    logic [dest_pkg::CNT_BITS-1:0]    count_reg, count_next;
    logic [dest_pkg::ENTRIES-1:0]     flags_reg, flags_next;
    logic [31:0]                      id_wide;
    logic                             match;
    logic                             full;

    assign id_wide = {{(32 - dest_pkg::EVID_BITS){1'b0}}, in_evt_id};
    assign match   = pend_reg && (rd_data == id_reg);
    assign full    = (count_reg == dest_pkg::CNT_BITS'(dest_pkg::ENTRIES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dest_pkg::ST_IDLE;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            scan_reg  <= '0;
            count_reg <= '0;
            flags_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
            scan_reg  <= scan_next;
            count_reg <= count_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        id_reg       <= id_next;
        pend_idx_reg <= pend_idx_next;
        hit_idx_reg  <= hit_idx_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        id_next       = id_reg;
        scan_next     = scan_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        count_next    = count_reg;
        flags_next    = flags_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        res.outcome   = dest_pkg::OUT_MISSING;
        res.active    = 1'b0;
        mem.we        = 1'b0;
        mem.waddr     = count_reg[dest_pkg::IDX_BITS-1:0];
        mem.wdata     = id_reg;
        mem.raddr     = scan_reg[dest_pkg::IDX_BITS-1:0];

        case (state_reg)
            dest_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mode_next  = in_mode;
                    id_next    = id_wide[dest_pkg::ID_BITS-1:0];
                    scan_next  = '0;
                    pend_next  = 1'b0;
                    hit_next   = 1'b0;
                    state_next = dest_pkg::ST_SCAN;
                end
            end

            dest_pkg::ST_SCAN:
            begin
                if (match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = pend_idx_reg;
                    pend_next    = 1'b0;
                    state_next   = dest_pkg::ST_DECIDE;
                end
                else if (scan_reg < count_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[dest_pkg::IDX_BITS-1:0];
                    scan_next     = scan_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = dest_pkg::ST_DECIDE;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            dest_pkg::ST_DECIDE:
            begin
                res_valid = 1'b1;
                case (mode_reg)
                    dest_pkg::MODE_REPORT:
                    begin
                        if (hit_reg)
                        begin
                            res.outcome = dest_pkg::OUT_FOUND;
                            res.active  = 1'b1;
                        end
                        else if (!full)
                        begin
                            res.outcome = dest_pkg::OUT_NEW;
                            res.active  = 1'b1;
                        end
                        else
                        begin
                            res.outcome = dest_pkg::OUT_FULL;
                        end
                    end
                    dest_pkg::MODE_CLEAR:
                    begin
                        if (hit_reg)
                        begin
                            res.outcome = dest_pkg::OUT_FOUND;
                        end
                    end
                    dest_pkg::MODE_CHECK:
                    begin
                        if (hit_reg)
                        begin
                            res.outcome = dest_pkg::OUT_FOUND;
                            res.active  = flags_reg[hit_idx_reg];
                        end
                    end
                    default:
                    begin
                        res.outcome = dest_pkg::OUT_MISSING;
                    end
                endcase

                if (res_take)
                begin
                    state_next = dest_pkg::ST_IDLE;
                    if (mode_reg == dest_pkg::MODE_REPORT)
                    begin
                        if (hit_reg)
                        begin
                            flags_next[hit_idx_reg] = 1'b1;
                        end
                        else if (!full)
                        begin
                            mem.we = 1'b1;
                            flags_next[count_reg[dest_pkg::IDX_BITS-1:0]] = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if ((mode_reg == dest_pkg::MODE_CLEAR) && hit_reg)
                    begin
                        flags_next[hit_idx_reg] = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = dest_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/diagnostic_event_status_table.sv
// ----------------------------------------------------------------------------
// Diagnostic event status table
// Table of event ids with active flags, searched by one shared comparator.
// ----------------------------------------------------------------------------
// One request is handled at a time: req.ready is high only while the block
// is idle. On a miss every stored id is compared; on a hit the scan stops
// at the matching entry. The stored ids sit in a single read port memory
// that is scanned one entry a cycle. The response is held in an output
// register; a stalled response keeps the next result and its table update
// waiting, and no new request is taken meanwhile. After reset the table is
// empty and usable at once.
module diagnostic_event_status_table (
    input  logic        clk,
    input  logic        rst_n,
    dest_req_if.sink    req,
    dest_rsp_if.source  rsp
);

    dest_pkg::mem_req_t           mem_req;
    logic [dest_pkg::ID_BITS-1:0] rd_data;
    logic                         res_valid;
    dest_pkg::res_t               res;
    logic                         res_take;
    logic                         rsp_valid_reg;
    logic [1:0]                   outcome_reg;
    logic                         active_reg;

    assign res_take = !rsp_valid_reg || rsp.ready;

    dest_id_mem u_id_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    dest_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_mode     (req.mode),
        .in_evt_id   (req.evt_id),
        .in_ready    (req.ready),
        .mem         (mem_req),
        .rd_data     (rd_data),
        .res_valid   (res_valid),
        .res         (res),
        .res_take    (res_take)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid && res_take)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            outcome_reg <= res.outcome;
            active_reg  <= res.active;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.outcome = outcome_reg;
    assign rsp.active  = active_reg;

endmodule

// File: hdl/dest_checker.sv
// ----------------------------------------------------------------------------
// Diagnostic event status table checker
// Port-level checks on the request and response channels.
// ----------------------------------------------------------------------------
`include "diagnostic_event_status_table_assert.svh"

module dest_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] rsp_outcome,
    input logic       rsp_active
);

    logic rsp_miss;
    logic rsp_new;

    assign rsp_miss = rsp_valid && ((rsp_outcome == dest_pkg::OUT_FULL)
                                 || (rsp_outcome == dest_pkg::OUT_MISSING));
    assign rsp_new  = rsp_valid && (rsp_outcome == dest_pkg::OUT_NEW);

    // a stalled response keeps its transfer pending
    `DEST_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)

    // only one request in flight
    `DEST_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready)

    // rejected or unknown ids never report active
    `DEST_ASSERT_SAME(a_miss_inactive, clk, rst_n, rsp_miss, !rsp_active)

    // a freshly added entry is always active
    `DEST_ASSERT_SAME(a_new_active, clk, rst_n, rsp_new, rsp_active)

endmodule

bind diagnostic_event_status_table dest_checker u_dest_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_outcome (rsp.outcome),
    .rsp_active  (rsp.active)
);

// File: bench/diagnostic_event_status_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Diagnostic event status table testbench
// Sends report, clear, check and unused-mode requests with random gaps on both channels.
// A scoreboard keeps its own copy of the table and compares each response
// with the outcome and active flag that it works out for that request.
// ----------------------------------------------------------------------------
module diagnostic_event_status_table_test;

    localparam logic [dest_pkg::MODE_BITS-1:0] MODE_UNUSED = 2'd3;
    localparam int GAP_PERCENT   = 14;
    localparam int RANDOM_ITEMS  = 1225;
    localparam int QUIET_FIRST   = 500;
    localparam int QUIET_LAST    = 800;
    localparam int DRAIN_AT      = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 50;

    class status_table_scoreboard;
        logic [dest_pkg::ID_BITS-1:0] id_list[dest_pkg::ENTRIES];
        bit                           flags[dest_pkg::ENTRIES];
        int                           stored;
        dest_pkg::res_t               awaited[$];
        int unsigned                  errors;

        function new();
            stored = 0;
            errors = 0;
            foreach (flags[i])
                flags[i] = 1'b0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_request(logic [dest_pkg::MODE_BITS-1:0] mode,
                                   logic [dest_pkg::EVID_BITS-1:0] evt_id);
            logic [dest_pkg::ID_BITS-1:0] id;
            int                           hit;
            dest_pkg::res_t               res;
            id = evt_id[dest_pkg::ID_BITS-1:0];
            hit = -1;
            for (int i = 0; i < stored; i++)
            begin
                if (hit < 0 && id_list[i] == id)
                    hit = i;
            end
            res.outcome = dest_pkg::OUT_MISSING;
            res.active  = 1'b0;
            case (mode)
                dest_pkg::MODE_REPORT:
                begin
                    if (hit >= 0)
                    begin
                        flags[hit]  = 1'b1;
                        res.outcome = dest_pkg::OUT_FOUND;
                        res.active  = 1'b1;
                    end
                    else if (stored < dest_pkg::ENTRIES)
                    begin
                        id_list[stored] = id;
                        flags[stored]   = 1'b1;
                        stored++;
                        res.outcome = dest_pkg::OUT_NEW;
                        res.active  = 1'b1;
                    end
                    else
                        res.outcome = dest_pkg::OUT_FULL;
                end
                dest_pkg::MODE_CLEAR:
                begin
                    if (hit >= 0)
                    begin
                        flags[hit]  = 1'b0;
                        res.outcome = dest_pkg::OUT_FOUND;
                    end
                end
                dest_pkg::MODE_CHECK:
                begin
                    if (hit >= 0)
                    begin
                        res.outcome = dest_pkg::OUT_FOUND;
                        res.active  = flags[hit];
                    end
                end
                default:
                    ;
            endcase
            awaited.push_back(res);
        endfunction

        function void check_response(logic [1:0] outcome, logic active);
            dest_pkg::res_t exp;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected response, expected none, actual %0d/%0b",
                             $time, outcome, active);
                return;
            end
            exp = awaited.pop_front();
            if (outcome !== exp.outcome)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: outcome mismatch, expected %0d actual %0d",
                             $time, exp.outcome, outcome);
            end
            if (active !== exp.active)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: active mismatch, expected %0b actual %0b",
                             $time, exp.active, active);
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   no_gaps = 1'b0;
    int   stall_cycles = 0;

    dest_req_if req();
    dest_rsp_if rsp();

    status_table_scoreboard sb = new();

    diagnostic_event_status_table i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit take_gap();
        return !no_gaps && ($urandom_range(99) < GAP_PERCENT);
    endfunction

    task automatic send_request(input logic [dest_pkg::MODE_BITS-1:0] m,
                                input logic [dest_pkg::EVID_BITS-1:0] id);
        while (take_gap())
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid  <= 1'b1;
        req.mode   <= m;
        req.evt_id <= id;
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_request(m, id);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // response side
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_response(rsp.outcome, rsp.active);
        rsp.ready <= rst_n && !take_gap();
    end

    // watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        logic [dest_pkg::MODE_BITS-1:0] op_choices[4];
        logic [dest_pkg::MODE_BITS-1:0] m;
        logic [dest_pkg::EVID_BITS-1:0] id;

        op_choices = '{dest_pkg::MODE_REPORT, dest_pkg::MODE_CLEAR,
                       dest_pkg::MODE_CHECK, MODE_UNUSED};
        req.valid  <= 1'b0;
        req.mode   <= dest_pkg::MODE_REPORT;
        req.evt_id <= '0;
        rst_n      <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, then extreme ids
        send_request(dest_pkg::MODE_CHECK,  16'h0000);
        send_request(dest_pkg::MODE_CLEAR,  16'h0000);
        send_request(dest_pkg::MODE_REPORT, 16'h0000);
        send_request(dest_pkg::MODE_REPORT, 16'hFFFF);
        send_request(dest_pkg::MODE_CHECK,  16'hFFFF);
        send_request(dest_pkg::MODE_CLEAR,  16'hFFFF);
        send_request(dest_pkg::MODE_CHECK,  16'hFFFF);
        send_request(dest_pkg::MODE_REPORT, 16'hFFFF);
        send_request(MODE_UNUSED, 16'hFFFF);
        send_request(MODE_UNUSED, 16'h0000);
        for (int k = 1; k <= dest_pkg::ENTRIES - 2; k++)
            send_request(dest_pkg::MODE_REPORT, 16'(16'h1111 * k));
        // table now full
        send_request(dest_pkg::MODE_REPORT, 16'h8001);
        send_request(dest_pkg::MODE_REPORT, 16'h1111);
        send_request(dest_pkg::MODE_CLEAR,  16'h7FFE);
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_gaps = (n >= QUIET_FIRST) && (n < QUIET_LAST);
            if (n == DRAIN_AT)
                wait_drained();
            if ($urandom_range(99) < 4)
                m = op_choices[3];
            else
                m = op_choices[$urandom_range(2)];
            if (sb.stored > 0 && $urandom_range(99) < 80)
                id = sb.id_list[$urandom_range(sb.stored - 1)];
            else
                id = 16'($urandom());
            send_request(m, id);
        end
        no_gaps = 1'b0;
        req.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/dest_pkg.sv
hdl/dest_req_if.sv
hdl/dest_rsp_if.sv
hdl/dest_id_mem.sv
hdl/dest_ctrl.sv
hdl/diagnostic_event_status_table.sv
hdl/dest_checker.sv
bench/diagnostic_event_status_table_test.sv
